/* hdl/ellipse_row_span_defines.svh */
// Assertion macros for the ellipse row span block.
// Included by modules that have clk and rst_n in scope; depends on nothing else.
`ifndef ELLIPSE_ROW_SPAN_DEFINES_SVH
`define ELLIPSE_ROW_SPAN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERS_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ers_pkg.sv */
// Package for the ellipse row span block: widths, register indexes, stage map.
// Used by ellipse_row_span; depends on nothing.
package ers_pkg;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int IDX_W   = 3;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
    localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 13'd4096;

    typedef enum logic [IDX_W-1:0] {
        REG_RECT_LEFT    = 3'd0,
        REG_RECT_TOP     = 3'd1,
        REG_RECT_WIDTH   = 3'd2,
        REG_RECT_HEIGHT  = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } cfg_reg_t;

    localparam int DY_W   = 15;
    localparam int SQR_W  = 28;
    localparam int REM_W  = 26;
    localparam int PROD_W = 52;
    localparam int ROOT_W = 26;
    localparam int QUO_W  = 13;
    localparam int POS_W  = 15;

    localparam int SQ_STEPS  = PROD_W / 2;
    localparam int DIV_STEPS = QUO_W;

    localparam int ST_DY    = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_REM   = 2;
    localparam int ST_PROD  = 3;
    localparam int ST_SQRT0 = 4;
    localparam int ST_DIV0  = ST_SQRT0 + SQ_STEPS;
    localparam int ST_ENDS  = ST_DIV0 + DIV_STEPS;
    localparam int ST_OUT   = ST_ENDS + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

endpackage

/* hdl/ellipse_row_span.sv */
// Ellipse row span: returns the covered column span of one image row.
// Pipeline: 4 setup stages, a 26-stage integer square root,
// a 13-stage restoring divider and 2 clip stages. Throughput is one row per cycle
// while in_stall is low; empty stages are filled while the output is stalled.
// Reset clears all stage valid bits and loads the configuration registers with their defaults.
// Depends on ers_pkg and ellipse_row_span_defines.svh.
`include "ellipse_row_span_defines.svh"

module ellipse_row_span (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ers_pkg::COORD_W-1:0]     row_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            span_valid,
    output logic [ers_pkg::COORD_W-1:0]     span_left,
    output logic [ers_pkg::COORD_W-1:0]     span_right,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ers_pkg::IDX_W-1:0]       cfg_index,
    input  logic [ers_pkg::DIM_W-1:0]       cfg_data
);

    localparam int NS = ers_pkg::NUM_STAGES;

    logic [ers_pkg::COORD_W-1:0] rect_left_reg;
    logic [ers_pkg::COORD_W-1:0] rect_top_reg;
    logic [ers_pkg::DIM_W-1:0]   rect_width_reg;
    logic [ers_pkg::DIM_W-1:0]   rect_height_reg;
    logic [ers_pkg::DIM_W-1:0]   image_width_reg;
    logic [ers_pkg::DIM_W-1:0]   image_height_reg;

    logic [ers_pkg::DIM_W-1:0]   img_w;
    logic [ers_pkg::DIM_W-1:0]   img_h;
    logic [ers_pkg::REM_W-1:0]   cfg_w2_reg;
    logic [ers_pkg::REM_W-1:0]   cfg_h2_reg;
    logic [ers_pkg::POS_W-1:0]   cfg_rlast_reg;
    logic [ers_pkg::POS_W-1:0]   cfg_iwlast_reg;

    logic [NS-1:0] st_valid_reg;
    logic [NS-1:0] st_valid_next;
    logic [NS-1:0] stage_ready;

    logic                             p0_ok_reg;
    logic signed [ers_pkg::DY_W-1:0]  p0_dy_reg;
    logic                             p1_ok_reg;
    logic [ers_pkg::SQR_W-1:0]        p1_dy2_reg;
    logic                             p2_ok_reg;
    logic [ers_pkg::REM_W-1:0]        p2_rem_reg;
    logic                             p3_ok_reg;
    logic [ers_pkg::PROD_W-1:0]       p3_prod_reg;

    logic                        sq_ok_reg  [ers_pkg::SQ_STEPS];
    logic [ers_pkg::PROD_W-1:0]  sq_v_reg   [ers_pkg::SQ_STEPS];
    logic [ers_pkg::PROD_W-1:0]  sq_r_reg   [ers_pkg::SQ_STEPS];

    logic                        dv_ok_reg  [ers_pkg::DIV_STEPS];
    logic [ers_pkg::REM_W-1:0]   dv_rem_reg [ers_pkg::DIV_STEPS];
    logic [ers_pkg::QUO_W-1:0]   dv_q_reg   [ers_pkg::DIV_STEPS];

    logic                        p4_ok_reg;
    logic [ers_pkg::POS_W-1:0]   p4_left_reg;
    logic [ers_pkg::POS_W-1:0]   p4_right_reg;

    logic                        span_valid_reg;
    logic [ers_pkg::COORD_W-1:0] span_left_reg;
    logic [ers_pkg::COORD_W-1:0] span_right_reg;

    logic                             row_ok;
    logic [ers_pkg::DY_W-1:0]         dy_calc;
    logic signed [2*ers_pkg::DY_W-1:0] dy_ext;
    logic signed [2*ers_pkg::DY_W-1:0] dy_sq;
    logic [ers_pkg::SQR_W-1:0]        rem_full;
    logic [ers_pkg::QUO_W-1:0]        quotient;
    logic [ers_pkg::POS_W:0]          span_base;
    logic [ers_pkg::POS_W:0]          left_num;
    logic [ers_pkg::POS_W:0]          right_num;
    logic [ers_pkg::POS_W-1:0]        rect_left_ext;
    logic [ers_pkg::POS_W-1:0]        left_clip;
    logic [ers_pkg::POS_W-1:0]        right_rect;
    logic [ers_pkg::POS_W-1:0]        right_clip;
    logic                             span_ok;
    logic                             in_accept;
    logic                             out_accept;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg    <= '0;
            rect_top_reg     <= '0;
            rect_width_reg   <= '0;
            rect_height_reg  <= '0;
            image_width_reg  <= ers_pkg::IMAGE_DIM_RESET;
            image_height_reg <= ers_pkg::IMAGE_DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ers_pkg::cfg_reg_t'(cfg_index))
                ers_pkg::REG_RECT_LEFT:    rect_left_reg    <= cfg_data[ers_pkg::COORD_W-1:0];
                ers_pkg::REG_RECT_TOP:     rect_top_reg     <= cfg_data[ers_pkg::COORD_W-1:0];
                ers_pkg::REG_RECT_WIDTH:   rect_width_reg   <= cfg_data;
                ers_pkg::REG_RECT_HEIGHT:  rect_height_reg  <= cfg_data;
                ers_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                ers_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign img_w = (image_width_reg > ers_pkg::MAX_DIM) ? ers_pkg::MAX_DIM : image_width_reg;
    assign img_h = (image_height_reg > ers_pkg::MAX_DIM) ? ers_pkg::MAX_DIM : image_height_reg;

    // Values derived from the configuration, refreshed every cycle.
    always_ff @(posedge clk)
    begin
        cfg_w2_reg     <= ers_pkg::REM_W'(rect_width_reg) * ers_pkg::REM_W'(rect_width_reg);
        cfg_h2_reg     <= ers_pkg::REM_W'(rect_height_reg) * ers_pkg::REM_W'(rect_height_reg);
        cfg_rlast_reg  <= ers_pkg::POS_W'(rect_left_reg) + ers_pkg::POS_W'(rect_width_reg)
                          - ers_pkg::POS_W'(1);
        cfg_iwlast_reg <= ers_pkg::POS_W'(img_w) - ers_pkg::POS_W'(1);
    end

    // Stage flow control: a stage loads when the output is not stalled or any stage from it to the output is empty.
    for (genvar k = 0; k < NS; k++)
    begin : g_ready
        assign stage_ready[k] = !out_stall || !(&st_valid_reg[NS-1:k]);
    end

    assign st_valid_next = (stage_ready & {st_valid_reg[NS-2:0], in_valid})
                         | (~stage_ready & st_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= '0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    assign in_stall  = !stage_ready[0];
    assign out_valid = st_valid_reg[NS-1];

    // Row range check and doubled vertical offset from the ellipse center.
    assign row_ok = (rect_width_reg != '0) && (rect_height_reg != '0) && (img_w != '0)
                 && (row_index >= rect_top_reg)
                 && (ers_pkg::POS_W'(row_index)
                     < ers_pkg::POS_W'(rect_top_reg) + ers_pkg::POS_W'(rect_height_reg))
                 && (ers_pkg::DIM_W'(row_index) < img_h);

    assign dy_calc = {2'b00, row_index, 1'b1} - {2'b00, rect_top_reg, 1'b0}
                   - {2'b00, rect_height_reg};

    assign dy_ext = (2*ers_pkg::DY_W)'(p0_dy_reg);
    assign dy_sq  = dy_ext * dy_ext;
    assign rem_full = ers_pkg::SQR_W'(cfg_h2_reg) - p1_dy2_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ready[ers_pkg::ST_DY])
        begin
            p0_ok_reg <= row_ok;
            p0_dy_reg <= $signed(dy_calc);
        end
        if (stage_ready[ers_pkg::ST_SQ])
        begin
            p1_ok_reg  <= p0_ok_reg;
            p1_dy2_reg <= dy_sq[ers_pkg::SQR_W-1:0];
        end
        if (stage_ready[ers_pkg::ST_REM])
        begin
            p2_ok_reg  <= p1_ok_reg;
            p2_rem_reg <= rem_full[ers_pkg::REM_W-1:0];
        end
        if (stage_ready[ers_pkg::ST_PROD])
        begin
            p3_ok_reg   <= p2_ok_reg;
            p3_prod_reg <= ers_pkg::PROD_W'(cfg_w2_reg) * ers_pkg::PROD_W'(p2_rem_reg);
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar j = 0; j < ers_pkg::SQ_STEPS; j++)
    begin : g_sqrt
        localparam int SHIFT = 2 * (ers_pkg::SQ_STEPS - 1 - j);
        localparam logic [ers_pkg::PROD_W-1:0] SQ_BIT = ers_pkg::PROD_W'(1) << SHIFT;

        logic                       ok_in;
        logic [ers_pkg::PROD_W-1:0] v_in;
        logic [ers_pkg::PROD_W-1:0] r_in;
        logic [ers_pkg::PROD_W:0]   trial;

        if (j == 0)
        begin : g_first
            assign ok_in = p3_ok_reg;
            assign v_in  = p3_prod_reg;
            assign r_in  = '0;
        end
        else
        begin : g_next
            assign ok_in = sq_ok_reg[j-1];
            assign v_in  = sq_v_reg[j-1];
            assign r_in  = sq_r_reg[j-1];
        end

        assign trial = {1'b0, r_in} + {1'b0, SQ_BIT};

        always_ff @(posedge clk)
        begin
            if (stage_ready[ers_pkg::ST_SQRT0 + j])
            begin
                sq_ok_reg[j] <= ok_in;
                if ({1'b0, v_in} >= trial)
                begin
                    sq_v_reg[j] <= v_in - trial[ers_pkg::PROD_W-1:0];
                    sq_r_reg[j] <= (r_in >> 1) + SQ_BIT;
                end
                else
                begin
                    sq_v_reg[j] <= v_in;
                    sq_r_reg[j] <= r_in >> 1;
                end
            end
        end
    end

    // Restoring division of the root by the rectangle height, MSB first.
    for (genvar i = 0; i < ers_pkg::DIV_STEPS; i++)
    begin : g_div
        localparam int QPOS = ers_pkg::DIV_STEPS - 1 - i;

        logic                       ok_in;
        logic [ers_pkg::REM_W-1:0]  rem_in;
        logic [ers_pkg::QUO_W-1:0]  q_in;
        logic [ers_pkg::REM_W-1:0]  divisor;
        logic                       fits;

        if (i == 0)
        begin : g_first
            assign ok_in  = sq_ok_reg[ers_pkg::SQ_STEPS-1];
            assign rem_in = sq_r_reg[ers_pkg::SQ_STEPS-1][ers_pkg::ROOT_W-1:0];
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign ok_in  = dv_ok_reg[i-1];
            assign rem_in = dv_rem_reg[i-1];
            assign q_in   = dv_q_reg[i-1];
        end

        assign divisor = ers_pkg::REM_W'(rect_height_reg) << QPOS;
        assign fits    = rem_in >= divisor;

        always_ff @(posedge clk)
        begin
            if (stage_ready[ers_pkg::ST_DIV0 + i])
            begin
                dv_ok_reg[i]  <= ok_in;
                dv_rem_reg[i] <= fits ? rem_in - divisor : rem_in;
                dv_q_reg[i]   <= {q_in[ers_pkg::QUO_W-2:0], fits};
            end
        end
    end

    // Span ends from the half width, then clipping.
    assign quotient  = dv_q_reg[ers_pkg::DIV_STEPS-1];
    assign span_base = {3'b000, rect_left_reg, 1'b0} + (ers_pkg::POS_W+1)'(rect_width_reg);
    assign left_num  = span_base - (ers_pkg::POS_W+1)'(quotient);
    assign right_num = span_base + (ers_pkg::POS_W+1)'(quotient) - (ers_pkg::POS_W+1)'(1);

    assign rect_left_ext = ers_pkg::POS_W'(rect_left_reg);
    assign left_clip  = (p4_left_reg < rect_left_ext) ? rect_left_ext : p4_left_reg;
    assign right_rect = (p4_right_reg > cfg_rlast_reg) ? cfg_rlast_reg : p4_right_reg;
    assign right_clip = (right_rect > cfg_iwlast_reg) ? cfg_iwlast_reg : right_rect;
    assign span_ok    = p4_ok_reg && (left_clip <= right_clip);

    always_ff @(posedge clk)
    begin
        if (stage_ready[ers_pkg::ST_ENDS])
        begin
            p4_ok_reg    <= dv_ok_reg[ers_pkg::DIV_STEPS-1];
            p4_left_reg  <= left_num[ers_pkg::POS_W:1];
            p4_right_reg <= right_num[ers_pkg::POS_W:1];
        end
        if (stage_ready[ers_pkg::ST_OUT])
        begin
            span_valid_reg <= span_ok;
            span_left_reg  <= span_ok ? left_clip[ers_pkg::COORD_W-1:0] : '0;
            span_right_reg <= span_ok ? right_clip[ers_pkg::COORD_W-1:0] : '0;
        end
    end

    assign span_valid = span_valid_reg;
    assign span_left  = span_left_reg;
    assign span_right = span_right_reg;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    `ERS_CHECK_NOW(a_full_only_when_blocked, in_stall, out_valid && out_stall, "input stalled while the pipeline can move")
    `ERS_CHECK_NEXT(a_occupancy_grows, in_accept && !out_accept, $countones(st_valid_reg) == $past($countones(st_valid_reg)) + 1, "stage occupancy did not grow on an accepted transaction")
    `ERS_CHECK_NOW(a_span_ordered, out_valid && span_valid, span_left <= span_right, "covered span has left end beyond right end")
    `ERS_CHECK_NOW(a_empty_span_zero, out_valid && !span_valid, (span_left == '0) && (span_right == '0), "empty span carries nonzero ends")

endmodule
